// ===== rtl/r2y420_pkg.sv =====
// Shared types, field widths and constants for the RGB to YUV 4:2:0 converter.
package r2y420_pkg;

  // Fixed field widths of the pixel and result transactions.
  localparam int PIXEL_W       = 32;
  localparam int SAMPLE_W      = 8;
  localparam int LUMA_ADDR_W   = 22;
  localparam int CHROMA_ADDR_W = 23;
  localparam int CHROMA_CNT_W  = 21;
  localparam int LANE_W        = 2;
  localparam int SIZE_CFG_W    = 12;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_PLANAR_LAYOUT = 3'd2,
    REG_RED_LANE      = 3'd3,
    REG_GREEN_LANE    = 3'd4,
    REG_BLUE_LANE     = 3'd5
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [SIZE_CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [SIZE_CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [LANE_W-1:0]     RST_RED_LANE     = 2'd0;
  localparam logic [LANE_W-1:0]     RST_GREEN_LANE   = 2'd1;
  localparam logic [LANE_W-1:0]     RST_BLUE_LANE    = 2'd2;

  // BT.601 integer coefficients; arithmetic is done in 16 bits.
  localparam int CALC_W = 16;
  localparam logic [CALC_W-1:0] Y_R_COEF  = 16'd66;
  localparam logic [CALC_W-1:0] Y_G_COEF  = 16'd129;
  localparam logic [CALC_W-1:0] Y_B_COEF  = 16'd25;
  localparam logic [CALC_W-1:0] Y_OFFSET  = 16'h1080;
  localparam logic [CALC_W-1:0] U_R_COEF  = 16'd38;
  localparam logic [CALC_W-1:0] U_G_COEF  = 16'd74;
  localparam logic [CALC_W-1:0] UV_COEF   = 16'd112;
  localparam logic [CALC_W-1:0] UV_OFFSET = 16'h8080;
  localparam logic [CALC_W-1:0] V_G_COEF  = 16'd94;
  localparam logic [CALC_W-1:0] V_B_COEF  = 16'd18;

endpackage

// ===== rtl/r2y420_in_if.sv =====
// Pixel input channel: valid/ready handshake with one packed pixel word.
interface r2y420_in_if
  import r2y420_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

// ===== rtl/r2y420_out_if.sv =====
// Result channel: valid/ready handshake with luma and chroma samples and addresses.
interface r2y420_out_if
  import r2y420_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      luma_value;
  logic [LUMA_ADDR_W-1:0]   luma_address;
  logic                     chroma_valid;
  logic [SAMPLE_W-1:0]      cb_value;
  logic [CHROMA_ADDR_W-1:0] cb_address;
  logic [SAMPLE_W-1:0]      cr_value;
  logic [CHROMA_ADDR_W-1:0] cr_address;
  logic                     frame_end;

  modport source (
    output valid, output luma_value, output luma_address, output chroma_valid,
    output cb_value, output cb_address, output cr_value, output cr_address,
    output frame_end, input ready
  );
  modport sink (
    input valid, input luma_value, input luma_address, input chroma_valid,
    input cb_value, input cb_address, input cr_value, input cr_address,
    input frame_end, output ready
  );
endinterface

// ===== rtl/rgb_to_yuv420_converter.sv =====
// Top level of the RGB to YUV 4:2:0 converter with frame addressing.
// An accepted pixel passes the input register and then the result register before its result appears.
// Throughput: one pixel per cycle; the two registers form a pipeline that advances on out ready.
// Lanes and layout act from the configuration registers, sizes also via the geometry registers, as a pixel loads.
// Reset (synchronous, rst_n low) empties the pipeline, clears the frame counters
// and returns the configuration registers to 640x480, semi-planar, lanes R0 G1 B2.
module rgb_to_yuv420_converter
  import r2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  r2y420_in_if.sink             in_ch,
  r2y420_out_if.source          out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Counter and size widths follow from the frame limits.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int FS_W  = WID_W + HGT_W;
  localparam int SUM_W = (FS_W + 1 > CHROMA_ADDR_W) ? FS_W + 1 : CHROMA_ADDR_W;
  localparam int CMPW_W = (WID_W > SIZE_CFG_W) ? WID_W : SIZE_CFG_W;
  localparam int CMPH_W = (HGT_W > SIZE_CFG_W) ? HGT_W : SIZE_CFG_W;

  // Configuration registers.
  logic [SIZE_CFG_W-1:0] frame_width_r, frame_height_r;
  logic                  planar_layout_r;
  logic [LANE_W-1:0]     red_lane_r, green_lane_r, blue_lane_r;

  // Derived frame geometry, refreshed every cycle from the configuration.
  logic [COL_W-1:0]         wlast_r;
  logic [ROW_W-1:0]         hlast_r;
  logic [CHROMA_ADDR_W-1:0] luma_end_r;
  logic [CHROMA_ADDR_W-1:0] cr_plane_r;

  // Pipeline: input register and result register.
  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               out_valid_r;
  logic               out_free;
  logic               s1_free;
  logic               s2_load;

  // Frame counters.
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [LUMA_ADDR_W-1:0]  luma_cnt_r, luma_cnt_nxt;
  logic [CHROMA_CNT_W-1:0] chroma_cnt_r, chroma_cnt_nxt;

  // Result register payload.
  logic [SAMPLE_W-1:0]      luma_value_r, luma_value_nxt;
  logic [LUMA_ADDR_W-1:0]   luma_address_r;
  logic                     chroma_valid_r;
  logic [SAMPLE_W-1:0]      cb_value_r, cb_value_nxt;
  logic [CHROMA_ADDR_W-1:0] cb_address_r, cb_address_nxt;
  logic [SAMPLE_W-1:0]      cr_value_r, cr_value_nxt;
  logic [CHROMA_ADDR_W-1:0] cr_address_r, cr_address_nxt;
  logic                     frame_end_r;

  // Configuration decode.
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  // Size clamping and frame size products.
  logic [CMPW_W-1:0]  width_ext;
  logic [CMPH_W-1:0]  height_ext;
  logic [WID_W-1:0]   width_eff;
  logic [HGT_W-1:0]   height_eff;
  logic [FS_W-1:0]    fsize;
  logic [SUM_W-1:0]   fsize_ext;
  logic [SUM_W-1:0]   fsize_5q;

  // Stage-two datapath.
  logic [CALC_W-1:0] red_s, green_s, blue_s;
  logic [CALC_W-1:0] y_sum, u_sum, v_sum;
  logic              chroma, last_col, last_row, frame_last;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  // Register write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      planar_layout_r <= 1'b0;
      red_lane_r      <= RST_RED_LANE;
      green_lane_r    <= RST_GREEN_LANE;
      blue_lane_r     <= RST_BLUE_LANE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_pwdata[SIZE_CFG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_pwdata[SIZE_CFG_W-1:0];
        REG_PLANAR_LAYOUT: planar_layout_r <= cfg_pwdata[0];
        REG_RED_LANE:      red_lane_r      <= cfg_pwdata[LANE_W-1:0];
        REG_GREEN_LANE:    green_lane_r    <= cfg_pwdata[LANE_W-1:0];
        REG_BLUE_LANE:     blue_lane_r     <= cfg_pwdata[LANE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read port.
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_FRAME_WIDTH:   cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:  cfg_prdata = CFG_DATA_W'(frame_height_r);
      REG_PLANAR_LAYOUT: cfg_prdata = CFG_DATA_W'(planar_layout_r);
      REG_RED_LANE:      cfg_prdata = CFG_DATA_W'(red_lane_r);
      REG_GREEN_LANE:    cfg_prdata = CFG_DATA_W'(green_lane_r);
      REG_BLUE_LANE:     cfg_prdata = CFG_DATA_W'(blue_lane_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // A zero size acts as one, and a size above the limit acts as the limit.
  always_comb begin
    width_ext  = CMPW_W'(frame_width_r);
    height_ext = CMPH_W'(frame_height_r);
    if (width_ext == '0) begin
      width_eff = WID_W'(1);
    end else if (width_ext > CMPW_W'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = WID_W'(width_ext);
    end
    if (height_ext == '0) begin
      height_eff = HGT_W'(1);
    end else if (height_ext > CMPH_W'(MAX_HEIGHT)) begin
      height_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      height_eff = HGT_W'(height_ext);
    end
    fsize     = FS_W'(width_eff) * FS_W'(height_eff);
    fsize_ext = SUM_W'(fsize);
    fsize_5q  = fsize_ext + (fsize_ext >> 2);
  end

  // Frame geometry registers; no reset needed, they follow the configuration.
  always_ff @(posedge clk) begin
    wlast_r    <= COL_W'(width_eff - WID_W'(1));
    hlast_r    <= ROW_W'(height_eff - HGT_W'(1));
    luma_end_r <= fsize_ext[CHROMA_ADDR_W-1:0];
    cr_plane_r <= fsize_5q[CHROMA_ADDR_W-1:0];
  end

  // Handshake: the result register frees when empty or taken, the input register when empty or when it moves on.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s2_load     = s1_valid_r && out_free;
  assign s1_free     = !s1_valid_r || out_free;
  assign in_ch.ready = s1_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_free) begin
      s1_pixel_r <= in_ch.pixel_word;
    end
  end

  // Color lanes and BT.601 weighted sums; every sum stays non-negative and under 16 bits.
  always_comb begin
    red_s   = CALC_W'(s1_pixel_r[8*red_lane_r +: SAMPLE_W]);
    green_s = CALC_W'(s1_pixel_r[8*green_lane_r +: SAMPLE_W]);
    blue_s  = CALC_W'(s1_pixel_r[8*blue_lane_r +: SAMPLE_W]);
    y_sum   = Y_R_COEF * red_s + Y_G_COEF * green_s + Y_B_COEF * blue_s + Y_OFFSET;
    u_sum   = (UV_COEF * blue_s + UV_OFFSET) - (U_R_COEF * red_s + U_G_COEF * green_s);
    v_sum   = (UV_COEF * red_s + UV_OFFSET) - (V_G_COEF * green_s + V_B_COEF * blue_s);
    luma_value_nxt = y_sum[CALC_W-1:CALC_W-SAMPLE_W];
  end

  // Position in the frame, chroma addresses and counter updates.
  always_comb begin
    chroma     = !row_r[0] && !col_r[0];
    last_col   = col_r >= wlast_r;
    last_row   = row_r >= hlast_r;
    frame_last = last_col && last_row;

    cb_value_nxt   = '0;
    cr_value_nxt   = '0;
    cb_address_nxt = '0;
    cr_address_nxt = '0;
    if (chroma) begin
      cb_value_nxt = u_sum[CALC_W-1:CALC_W-SAMPLE_W];
      cr_value_nxt = v_sum[CALC_W-1:CALC_W-SAMPLE_W];
      if (planar_layout_r) begin
        cb_address_nxt = luma_end_r + CHROMA_ADDR_W'(chroma_cnt_r);
        cr_address_nxt = cr_plane_r + CHROMA_ADDR_W'(chroma_cnt_r);
      end else begin
        cb_address_nxt = luma_end_r + {1'b0, chroma_cnt_r, 1'b0};
        cr_address_nxt = luma_end_r + {1'b0, chroma_cnt_r, 1'b1};
      end
    end

    col_nxt        = col_r;
    row_nxt        = row_r;
    luma_cnt_nxt   = luma_cnt_r;
    chroma_cnt_nxt = chroma_cnt_r;
    if (frame_last) begin
      col_nxt        = '0;
      row_nxt        = '0;
      luma_cnt_nxt   = '0;
      chroma_cnt_nxt = '0;
    end else begin
      luma_cnt_nxt = luma_cnt_r + LUMA_ADDR_W'(1);
      if (chroma) begin
        chroma_cnt_nxt = chroma_cnt_r + CHROMA_CNT_W'(1);
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Frame counters advance once per pixel entering the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      luma_cnt_r   <= '0;
      chroma_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s2_load) begin
        col_r        <= col_nxt;
        row_r        <= row_nxt;
        luma_cnt_r   <= luma_cnt_nxt;
        chroma_cnt_r <= chroma_cnt_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      luma_value_r   <= luma_value_nxt;
      luma_address_r <= luma_cnt_r;
      chroma_valid_r <= chroma;
      cb_value_r     <= cb_value_nxt;
      cb_address_r   <= cb_address_nxt;
      cr_value_r     <= cr_value_nxt;
      cr_address_r   <= cr_address_nxt;
      frame_end_r    <= frame_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.luma_value   = luma_value_r;
  assign out_ch.luma_address = luma_address_r;
  assign out_ch.chroma_valid = chroma_valid_r;
  assign out_ch.cb_value     = cb_value_r;
  assign out_ch.cb_address   = cb_address_r;
  assign out_ch.cr_value     = cr_value_r;
  assign out_ch.cr_address   = cr_address_r;
  assign out_ch.frame_end    = frame_end_r;

`ifndef SYNTHESIS
  // The last pixel of a frame returns every counter to the frame origin.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && frame_last) |=>
      (col_r == '0 && row_r == '0 && luma_cnt_r == '0 && chroma_cnt_r == '0))
    else $error("frame counters not cleared after frame end");

  // Pixels without chroma carry zero chroma fields.
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !chroma_valid_r) |->
      (cb_value_r == '0 && cr_value_r == '0 && cb_address_r == '0 && cr_address_r == '0))
    else $error("chroma fields set on a pixel without chroma");

  // In the semi-planar layout V sits right after its U sample.
  a_semi_planar_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && chroma_valid_r && !planar_layout_r) |->
      (cr_address_r == cb_address_r + CHROMA_ADDR_W'(1)))
    else $error("interleaved chroma addresses are not adjacent");
`endif

endmodule

// ===== dv/rgb_to_yuv420_converter_tb.sv =====
// Self-checking testbench for the RGB to YUV 4:2:0 converter with APB register checks.
module rgb_to_yuv420_converter_tb;
  import r2y420_pkg::*;

  localparam int FRAME_MAX_W   = 2048;
  localparam int FRAME_MAX_H   = 2048;
  localparam int SPARE_REG_LO  = 6;
  localparam int SPARE_REG_HI  = 7;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 1900;
  localparam int MAX_LOGGED    = 40;

  // Register programming done ahead of a directed pixel.
  typedef enum int {SETUP_KEEP, SETUP_TINY, SETUP_HUGE, SETUP_SHRINK} setup_step_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      luma_value;
    logic [LUMA_ADDR_W-1:0]   luma_address;
    logic                     chroma_valid;
    logic [SAMPLE_W-1:0]      cb_value;
    logic [CHROMA_ADDR_W-1:0] cb_address;
    logic [SAMPLE_W-1:0]      cr_value;
    logic [CHROMA_ADDR_W-1:0] cr_address;
    logic                     frame_end;
  } yuv_result_t;

  // One directed pixel; the samples are typed in only where pinned is set.
  typedef struct {
    setup_step_t         setup;
    logic [PIXEL_W-1:0]  word;
    bit                  pinned;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] u;
    logic [SAMPLE_W-1:0] v;
  } stim_row_t;

  stim_row_t directed_rows [24] = '{
    '{SETUP_KEEP,   32'h0000_0000, 1'b1, 8'd16,  8'd128, 8'd128},
    '{SETUP_KEEP,   32'h00FF_FFFF, 1'b1, 8'd235, 8'd128, 8'd128},
    '{SETUP_KEEP,   32'h0000_00FF, 1'b1, 8'd82,  8'd90,  8'd240},
    '{SETUP_KEEP,   32'h0000_FF00, 1'b1, 8'd144, 8'd54,  8'd34},
    '{SETUP_KEEP,   32'h00FF_0000, 1'b1, 8'd41,  8'd240, 8'd110},
    '{SETUP_KEEP,   32'hFF00_0000, 1'b1, 8'd16,  8'd128, 8'd128},
    '{SETUP_KEEP,   32'hFFFF_FFFF, 1'b1, 8'd235, 8'd128, 8'd128},
    '{SETUP_KEEP,   32'hA5A5_A5A5, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_TINY,   32'hFF00_0000, 1'b1, 8'd235, 8'd128, 8'd128},
    '{SETUP_KEEP,   32'h7F00_FF00, 1'b1, 8'd125, 8'd128, 8'd128},
    '{SETUP_KEEP,   32'h8012_3456, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'h01FE_DCBA, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_HUGE,   32'h0000_0000, 1'b1, 8'd16,  8'd128, 8'd128},
    '{SETUP_KEEP,   32'h1234_5678, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'hFFFF_FFFF, 1'b1, 8'd235, 8'd128, 8'd128},
    '{SETUP_KEEP,   32'h0F0F_0F0F, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_SHRINK, 32'h0000_00FF, 1'b1, 8'd41,  8'd240, 8'd110},
    '{SETUP_KEEP,   32'h00FF_0000, 1'b1, 8'd82,  8'd90,  8'd240},
    '{SETUP_KEEP,   32'h3C3C_3C3C, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'hC3C3_C3C3, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'h00FF_00FF, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'hFF00_FF00, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'h1357_9BDF, 1'b0, 8'd0,   8'd0,   8'd0},
    '{SETUP_KEEP,   32'h2468_ACE0, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  r2y420_in_if  in_ch ();
  r2y420_out_if out_ch ();

  // Register copies and frame counters of the converter model.
  logic [SIZE_CFG_W-1:0]   cfg_width   = RST_FRAME_WIDTH;
  logic [SIZE_CFG_W-1:0]   cfg_height  = RST_FRAME_HEIGHT;
  logic                    cfg_planar  = 1'b0;
  logic [LANE_W-1:0]       lane_r      = RST_RED_LANE;
  logic [LANE_W-1:0]       lane_g      = RST_GREEN_LANE;
  logic [LANE_W-1:0]       lane_b      = RST_BLUE_LANE;
  logic [10:0]             col_cnt     = '0;
  logic [10:0]             row_cnt     = '0;
  logic [LUMA_ADDR_W-1:0]  luma_idx    = '0;
  logic [CHROMA_CNT_W-1:0] chroma_idx  = '0;

  yuv_result_t pending_yuv [$];
  stim_row_t   pinned_q [$];

  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned frame_ends     = 0;
  int unsigned chroma_hits    = 0;
  int unsigned setting_count  = 0;
  int unsigned quiet_cycles   = 0;
  bit          gaps_on        = 1'b1;
  bit          stall_on       = 1'b1;

  rgb_to_yuv420_converter #(
    .MAX_WIDTH  (FRAME_MAX_W),
    .MAX_HEIGHT (FRAME_MAX_H)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Size registers: zero acts as one, anything above the maximum acts as the maximum.
  function automatic int unsigned clamp_size(input logic [SIZE_CFG_W-1:0] v,
                                             input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Computes the result of one pixel and advances the frame counters.
  function automatic yuv_result_t convert_pixel(input logic [PIXEL_W-1:0] word);
    yuv_result_t res;
    int unsigned r, g, b, w, h, fsize, cb_addr, cr_addr;
    bit          chroma, last_col, last_row;
    r = (word >> (8 * lane_r)) & 32'hFF;
    g = (word >> (8 * lane_g)) & 32'hFF;
    b = (word >> (8 * lane_b)) & 32'hFF;
    w = clamp_size(cfg_width, FRAME_MAX_W);
    h = clamp_size(cfg_height, FRAME_MAX_H);
    fsize = w * h;
    chroma   = !row_cnt[0] && !col_cnt[0];
    last_col = col_cnt >= w - 1;
    last_row = row_cnt >= h - 1;

    res = '0;
    res.luma_value   = SAMPLE_W'((66 * r + 129 * g + 25 * b + 32'h1080) >> 8);
    res.luma_address = luma_idx;
    res.chroma_valid = chroma;
    res.frame_end    = last_col && last_row;
    if (chroma) begin
      if (cfg_planar) begin
        cb_addr = fsize + chroma_idx;
        cr_addr = fsize + fsize / 4 + chroma_idx;
      end else begin
        cb_addr = fsize + 2 * chroma_idx;
        cr_addr = cb_addr + 1;
      end
      res.cb_value   = SAMPLE_W'(((112 * b + 32'h8080) - (38 * r + 74 * g)) >> 8);
      res.cr_value   = SAMPLE_W'(((112 * r + 32'h8080) - (94 * g + 18 * b)) >> 8);
      res.cb_address = CHROMA_ADDR_W'(cb_addr);
      res.cr_address = CHROMA_ADDR_W'(cr_addr);
    end

    // All counters restart after the last pixel of the frame.
    if (last_col && last_row) begin
      col_cnt    = '0;
      row_cnt    = '0;
      luma_idx   = '0;
      chroma_idx = '0;
    end else begin
      luma_idx = luma_idx + 1'b1;
      if (chroma) chroma_idx = chroma_idx + 1'b1;
      if (last_col) begin
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] register_shadow(input int unsigned idx);
    case (idx)
      REG_FRAME_WIDTH:   return CFG_DATA_W'(cfg_width);
      REG_FRAME_HEIGHT:  return CFG_DATA_W'(cfg_height);
      REG_PLANAR_LAYOUT: return CFG_DATA_W'(cfg_planar);
      REG_RED_LANE:      return CFG_DATA_W'(lane_r);
      REG_GREEN_LANE:    return CFG_DATA_W'(lane_g);
      REG_BLUE_LANE:     return CFG_DATA_W'(lane_b);
      default:           return '0;
    endcase
  endfunction

  // Idle lengths: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'hFF << (8 * $urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Frame sizes lean small so that frames wrap often; the extremes show up too.
  function automatic logic [CFG_DATA_W-1:0] random_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(1, 6);
    if (roll < 80) return $urandom_range(7, 40);
    if (roll < 86) return 0;
    if (roll < 91) return FRAME_MAX_W;
    if (roll < 95) return 4095;
    return $urandom_range(41, 4095);
  endfunction

  // Sets random bits above the field that the register keeps, now and then.
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] v,
                                                       input int unsigned kept_bits);
    if ($urandom_range(0, 3) != 0) return v;
    return v | (CFG_DATA_W'($urandom()) << kept_bits);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_LOGGED) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want, input int unsigned num);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             num, field, got, want));
  endtask

  task automatic cfg_write(input int unsigned idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // Mirror the write; indexes past the register list are ignored.
    case (idx)
      REG_FRAME_WIDTH:   cfg_width  = data[SIZE_CFG_W-1:0];
      REG_FRAME_HEIGHT:  cfg_height = data[SIZE_CFG_W-1:0];
      REG_PLANAR_LAYOUT: cfg_planar = data[0];
      REG_RED_LANE:      lane_r     = data[LANE_W-1:0];
      REG_GREEN_LANE:    lane_g     = data[LANE_W-1:0];
      REG_BLUE_LANE:     lane_b     = data[LANE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_register(input int unsigned idx, input logic [CFG_DATA_W-1:0] want);
    logic [CFG_DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want)
      log_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h", idx, got, want));
    @(posedge clk);
  endtask

  task automatic readback_all();
    for (int unsigned i = REG_FRAME_WIDTH; i <= REG_BLUE_LANE; i++)
      check_register(i, register_shadow(i));
  endtask

  task automatic program_frame(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] ht,
                               input logic [CFG_DATA_W-1:0] layout,
                               input logic [CFG_DATA_W-1:0] rl, input logic [CFG_DATA_W-1:0] gl,
                               input logic [CFG_DATA_W-1:0] bl);
    cfg_write(REG_FRAME_WIDTH, wd);
    cfg_write(REG_FRAME_HEIGHT, ht);
    cfg_write(REG_PLANAR_LAYOUT, layout);
    cfg_write(REG_RED_LANE, rl);
    cfg_write(REG_GREEN_LANE, gl);
    cfg_write(REG_BLUE_LANE, bl);
  endtask

  // Drops valid and waits until every sent pixel has produced its result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (results_seen < pixels_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] word);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    in_ch.valid      <= 1'b1;
    in_ch.pixel_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apply_setup(input setup_step_t step);
    drain_results();
    case (step)
      SETUP_TINY: begin
        // Zero sizes act as a 1x1 frame; all three colors read the top byte.
        program_frame(0, 0, 1, 3, 3, 3);
        cfg_write(SPARE_REG_LO, $urandom());
        cfg_write(SPARE_REG_HI, '1);
      end
      SETUP_HUGE: begin
        program_frame(4095, 4095, 1, 3, 2, 1);
      end
      SETUP_SHRINK: begin
        program_frame(with_noise(2, SIZE_CFG_W), 3, 0, 2, 1, 0);
      end
      default: ;
    endcase
    readback_all();
    setting_count++;
  endtask

  // Result stalls: random runs of ready, with gaps while stall_on is set.
  initial begin : result_backpressure
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      if (stall_on) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // Scoreboard: compare each result transaction, then predict from each pixel transaction.
  always @(posedge clk) begin : scoreboard
    yuv_result_t want;
    stim_row_t   pin;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_yuv.size() == 0) begin
          log_mismatch("result transaction with no pixel outstanding");
        end else begin
          want = pending_yuv.pop_front();
          check_field("luma_value", out_ch.luma_value, want.luma_value, results_seen);
          check_field("luma_address", out_ch.luma_address, want.luma_address, results_seen);
          check_field("chroma_valid", out_ch.chroma_valid, want.chroma_valid, results_seen);
          check_field("cb_value", out_ch.cb_value, want.cb_value, results_seen);
          check_field("cb_address", out_ch.cb_address, want.cb_address, results_seen);
          check_field("cr_value", out_ch.cr_value, want.cr_value, results_seen);
          check_field("cr_address", out_ch.cr_address, want.cr_address, results_seen);
          check_field("frame_end", out_ch.frame_end, want.frame_end, results_seen);
          results_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = convert_pixel(in_ch.pixel_word);
        // Directed pixels may carry hand-computed samples.
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pinned) begin
            want.luma_value = pin.y;
            if (want.chroma_valid) begin
              want.cb_value = pin.u;
              want.cr_value = pin.v;
            end
          end
        end
        if (want.frame_end) frame_ends++;
        if (want.chroma_valid) chroma_hits++;
        pending_yuv.push_back(want);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_yuv.size());
      $display("FAIL rgb_to_yuv420_converter");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned burst;
    int unsigned directed_total;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pixel_word = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers come out of reset at 640x480, semi-planar, lanes R0 G1 B2.
    check_register(REG_FRAME_WIDTH, 32'd640);
    check_register(REG_FRAME_HEIGHT, 32'd480);
    check_register(REG_PLANAR_LAYOUT, 32'd0);
    check_register(REG_RED_LANE, 32'd0);
    check_register(REG_GREEN_LANE, 32'd1);
    check_register(REG_BLUE_LANE, 32'd2);

    // Directed pixels: color extremes, coinciding lanes, size clamping, mid-frame resize.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setup != SETUP_KEEP) apply_setup(directed_rows[i].setup);
      pinned_q.push_back(directed_rows[i]);
      send_pixel(directed_rows[i].word);
    end
    directed_total = pixels_sent;

    // Random bursts, each under a fresh register setting; counters carry across settings.
    while (pixels_sent < directed_total + RANDOM_PIXELS) begin
      drain_results();
      program_frame(with_noise(random_size(), SIZE_CFG_W),
                    with_noise(random_size(), SIZE_CFG_W),
                    with_noise($urandom_range(0, 1), 1),
                    with_noise($urandom_range(0, 3), LANE_W),
                    with_noise($urandom_range(0, 3), LANE_W),
                    with_noise($urandom_range(0, 3), LANE_W));
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(SPARE_REG_LO, SPARE_REG_HI), $urandom());
      readback_all();
      setting_count++;
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(40, 200);
      for (int unsigned k = 0; k < burst; k++) begin
        // Some bursts stop halfway until the converter has emptied.
        if (k == burst / 2 && setting_count % 3 == 1) drain_results();
        send_pixel(random_pixel());
      end
    end

    drain_results();
    if (pending_yuv.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_yuv.size()));
    $display("Summary: %0d pixels under %0d register settings, %0d with chroma, %0d frame ends.",
             pixels_sent, setting_count, chroma_hits, frame_ends);
    $display("Summary: %0d results compared, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS rgb_to_yuv420_converter");
    else
      $display("FAIL rgb_to_yuv420_converter");
    $finish;
  end

endmodule
